### sv/pmcs_pkg.sv
// pmcs_pkg: shared types, constants and helpers of the profile mode command sequencer
// no dependencies; used by the channel interfaces, the core and its checker

package pmcs_pkg;

    // number of motor slots with their own sequence state
    localparam int MOTORS      = 16;
    localparam int MOTOR_IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // field widths
    localparam int SLOT_W  = 4;
    localparam int NODE_W  = 7;
    localparam int CODE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 8;
    localparam int STEP_W  = 2;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 8;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CODE_TARGET_POSITION  = 3'd0,
        REG_CODE_TARGET_VELOCITY  = 3'd1,
        REG_CODE_CONTROLWORD      = 3'd2,
        REG_CODE_SET_MODE         = 3'd3,
        REG_CODE_IDLE             = 3'd4,
        REG_MODE_PROFILE_POSITION = 3'd5,
        REG_MODE_PROFILE_VELOCITY = 3'd6,
        REG_MODE_INITIAL          = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [CODE_W-1:0] RST_CODE_TARGET_POSITION  = 8'd1;
    localparam logic [CODE_W-1:0] RST_CODE_TARGET_VELOCITY  = 8'd2;
    localparam logic [CODE_W-1:0] RST_CODE_CONTROLWORD      = 8'd3;
    localparam logic [CODE_W-1:0] RST_CODE_SET_MODE         = 8'd4;
    localparam logic [CODE_W-1:0] RST_CODE_IDLE             = 8'd0;
    localparam logic [MODE_W-1:0] RST_MODE_PROFILE_POSITION = 8'h01;
    localparam logic [MODE_W-1:0] RST_MODE_PROFILE_VELOCITY = 8'h03;
    localparam logic [MODE_W-1:0] RST_MODE_INITIAL          = 8'hFD;

    // controlword values of the drive state sequence
    localparam logic [VALUE_W-1:0] CW_LOW_POS  = 32'h0000_002F;
    localparam logic [VALUE_W-1:0] CW_HIGH_POS = 32'h0000_003F;
    localparam logic [VALUE_W-1:0] CW_VEL      = 32'h0000_000F;

    // sequence steps
    localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MODE  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_LOW   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_HIGH  = 2'd3;

    // sign-extend a mode number to a command argument
    function automatic logic [VALUE_W-1:0] widen_mode(input logic [MODE_W-1:0] m);
        return {{(VALUE_W-MODE_W){m[MODE_W-1]}}, m};
    endfunction

endpackage

### sv/pmcs_in_if.sv
// pmcs_in_if: command request channel (valid, ready, slot, node id, code, value)
// depends on pmcs_pkg for field widths

interface pmcs_in_if;
    logic                              valid;
    logic                              ready;
    logic [pmcs_pkg::SLOT_W-1:0]       motor_slot;
    logic [pmcs_pkg::NODE_W-1:0]       node_id;
    logic [pmcs_pkg::CODE_W-1:0]       command_code;
    logic signed [pmcs_pkg::VALUE_W-1:0] command_value;

    modport source (output valid, output motor_slot, output node_id,
                    output command_code, output command_value, input ready);
    modport sink   (input valid, input motor_slot, input node_id,
                    input command_code, input command_value, output ready);
endinterface

### sv/pmcs_out_if.sv
// pmcs_out_if: drive command channel (valid, ready, node id, command, value)
// depends on pmcs_pkg for field widths

interface pmcs_out_if;
    logic                              valid;
    logic                              ready;
    logic [pmcs_pkg::NODE_W-1:0]       out_node_id;
    logic [pmcs_pkg::CODE_W-1:0]       out_command;
    logic signed [pmcs_pkg::VALUE_W-1:0] out_value;

    modport source (output valid, output out_node_id, output out_command,
                    output out_value, input ready);
    modport sink   (input valid, input out_node_id, input out_command,
                    input out_value, output ready);
endinterface

### sv/profile_mode_command_sequencer_core.sv
// profile_mode_command_sequencer_core: per-slot profile mode sequencer, one command in, one out
// depends on pmcs_pkg, pmcs_in_if and pmcs_out_if
// the drive command beat is registered and appears in the cycle after the request beat is taken
// throughput: one beat per cycle unless rsp.ready stalls; the per-slot state is read, updated
// and written back in the same cycle the beat is taken, with the result in the output register
// reset: all slots idle, saved node 0, active mode -3; code and mode registers at defaults

module profile_mode_command_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pmcs_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [pmcs_pkg::REG_DATA_W-1:0]     wr_data,
    pmcs_in_if.sink                             req,
    pmcs_out_if.source                          rsp
);

    // configuration registers
    logic [pmcs_pkg::CODE_W-1:0] code_tp_reg;
    logic [pmcs_pkg::CODE_W-1:0] code_tv_reg;
    logic [pmcs_pkg::CODE_W-1:0] code_cw_reg;
    logic [pmcs_pkg::CODE_W-1:0] code_sm_reg;
    logic [pmcs_pkg::CODE_W-1:0] code_idle_reg;
    logic [pmcs_pkg::MODE_W-1:0] mode_pp_reg;
    logic [pmcs_pkg::MODE_W-1:0] mode_pv_reg;

    // per-slot state
    logic [pmcs_pkg::STEP_W-1:0] position_step_reg [pmcs_pkg::MOTORS];
    logic [pmcs_pkg::STEP_W-1:0] velocity_step_reg [pmcs_pkg::MOTORS];
    logic [pmcs_pkg::MODE_W-1:0] active_mode_reg   [pmcs_pkg::MOTORS];
    logic [pmcs_pkg::NODE_W-1:0] saved_node_reg    [pmcs_pkg::MOTORS];

    // output register
    logic                         out_valid_reg;
    logic [pmcs_pkg::NODE_W-1:0]  out_node_reg;
    logic [pmcs_pkg::CODE_W-1:0]  out_cmd_reg;
    logic [pmcs_pkg::VALUE_W-1:0] out_val_reg;

    // datapath signals
    logic                            accept;
    logic                            beyond;
    logic [pmcs_pkg::MOTOR_IDX_W-1:0] idx;
    logic                            is_tp;
    logic                            is_tv;
    logic                            replaced;
    logic [pmcs_pkg::STEP_W-1:0]     ps_next;
    logic [pmcs_pkg::STEP_W-1:0]     vs_next;
    logic [pmcs_pkg::MODE_W-1:0]     am_next;
    logic [pmcs_pkg::NODE_W-1:0]     sn_next;
    logic [pmcs_pkg::NODE_W-1:0]     node_next;
    logic [pmcs_pkg::CODE_W-1:0]     cmd_next;
    logic [pmcs_pkg::VALUE_W-1:0]    val_next;

    // handshake: take a new beat whenever the output register is free or drains
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign beyond = (32'(req.motor_slot) >= pmcs_pkg::MOTORS);
    assign idx    = pmcs_pkg::MOTOR_IDX_W'(req.motor_slot);
    assign is_tp  = (req.command_code == code_tp_reg);
    assign is_tv  = (req.command_code == code_tv_reg);

    // configuration writes; the initial mode register only sets the reset value,
    // which is fixed, so a write to it has no effect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_tp_reg   <= pmcs_pkg::RST_CODE_TARGET_POSITION;
            code_tv_reg   <= pmcs_pkg::RST_CODE_TARGET_VELOCITY;
            code_cw_reg   <= pmcs_pkg::RST_CODE_CONTROLWORD;
            code_sm_reg   <= pmcs_pkg::RST_CODE_SET_MODE;
            code_idle_reg <= pmcs_pkg::RST_CODE_IDLE;
            mode_pp_reg   <= pmcs_pkg::RST_MODE_PROFILE_POSITION;
            mode_pv_reg   <= pmcs_pkg::RST_MODE_PROFILE_VELOCITY;
        end
        else if (wr_en)
        begin
            case (pmcs_pkg::reg_idx_t'(wr_index))
                pmcs_pkg::REG_CODE_TARGET_POSITION:  code_tp_reg   <= wr_data;
                pmcs_pkg::REG_CODE_TARGET_VELOCITY:  code_tv_reg   <= wr_data;
                pmcs_pkg::REG_CODE_CONTROLWORD:      code_cw_reg   <= wr_data;
                pmcs_pkg::REG_CODE_SET_MODE:         code_sm_reg   <= wr_data;
                pmcs_pkg::REG_CODE_IDLE:             code_idle_reg <= wr_data;
                pmcs_pkg::REG_MODE_PROFILE_POSITION: mode_pp_reg   <= wr_data;
                pmcs_pkg::REG_MODE_PROFILE_VELOCITY: mode_pv_reg   <= wr_data;
                default:                             ;
            endcase
        end
    end

    // sequence logic: position rule first, then velocity rule
    always_comb
    begin
        logic [pmcs_pkg::STEP_W-1:0] ps;
        logic [pmcs_pkg::STEP_W-1:0] vs;
        ps        = position_step_reg[idx];
        vs        = velocity_step_reg[idx];
        ps_next   = ps;
        vs_next   = vs;
        am_next   = active_mode_reg[idx];
        sn_next   = saved_node_reg[idx];
        node_next = req.node_id;
        cmd_next  = code_idle_reg;
        val_next  = '0;
        replaced  = 1'b0;

        if (!is_tp && !is_tv)
        begin
            cmd_next = req.command_code;
            val_next = req.command_value;
        end

        // position sequence
        case (ps)
            pmcs_pkg::STEP_MODE:
            begin
                node_next = sn_next;
                if (am_next == mode_pp_reg)
                begin
                    cmd_next = code_cw_reg;
                    val_next = pmcs_pkg::CW_LOW_POS;
                    ps_next  = pmcs_pkg::STEP_HIGH;
                end
                else
                begin
                    cmd_next = code_sm_reg;
                    val_next = pmcs_pkg::widen_mode(mode_pp_reg);
                    ps_next  = pmcs_pkg::STEP_LOW;
                    am_next  = mode_pp_reg;
                end
                replaced = 1'b1;
            end
            pmcs_pkg::STEP_LOW:
            begin
                node_next = sn_next;
                cmd_next  = code_cw_reg;
                val_next  = pmcs_pkg::CW_LOW_POS;
                ps_next   = pmcs_pkg::STEP_HIGH;
                replaced  = 1'b1;
            end
            pmcs_pkg::STEP_HIGH:
            begin
                node_next = sn_next;
                cmd_next  = code_cw_reg;
                val_next  = pmcs_pkg::CW_HIGH_POS;
                ps_next   = pmcs_pkg::STEP_IDLE;
                replaced  = 1'b1;
            end
            default:
            begin
                if (is_tp)
                begin
                    sn_next  = node_next;
                    cmd_next = req.command_code;
                    val_next = req.command_value;
                    ps_next  = pmcs_pkg::STEP_MODE;
                end
                replaced = 1'b0;
            end
        endcase

        // velocity sequence; the unused top step behaves as idle
        case (vs)
            pmcs_pkg::STEP_MODE:
            begin
                node_next = sn_next;
                if (am_next == mode_pv_reg)
                begin
                    cmd_next = code_cw_reg;
                    val_next = pmcs_pkg::CW_VEL;
                    vs_next  = pmcs_pkg::STEP_IDLE;
                end
                else
                begin
                    cmd_next = code_sm_reg;
                    val_next = pmcs_pkg::widen_mode(mode_pv_reg);
                    vs_next  = pmcs_pkg::STEP_LOW;
                    am_next  = mode_pv_reg;
                end
                replaced = 1'b1;
            end
            pmcs_pkg::STEP_LOW:
            begin
                node_next = sn_next;
                cmd_next  = code_cw_reg;
                val_next  = pmcs_pkg::CW_VEL;
                vs_next   = pmcs_pkg::STEP_IDLE;
                replaced  = 1'b1;
            end
            default:
            begin
                if (is_tv)
                begin
                    sn_next  = node_next;
                    cmd_next = req.command_code;
                    val_next = req.command_value;
                    vs_next  = pmcs_pkg::STEP_MODE;
                end
                replaced = 1'b0;
            end
        endcase

        // a set-mode request updates the slot's mode unless the velocity sequence replaced it
        if (!replaced && (req.command_code == code_sm_reg))
        begin
            am_next = req.command_value[pmcs_pkg::MODE_W-1:0];
        end

        // slot with no state: plain pass-through
        if (beyond)
        begin
            node_next = req.node_id;
            cmd_next  = req.command_code;
            val_next  = req.command_value;
        end
    end

    // per-slot state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pmcs_pkg::MOTORS; k++)
            begin
                position_step_reg[k] <= pmcs_pkg::STEP_IDLE;
                velocity_step_reg[k] <= pmcs_pkg::STEP_IDLE;
                active_mode_reg[k]   <= pmcs_pkg::RST_MODE_INITIAL;
                saved_node_reg[k]    <= '0;
            end
        end
        else if (accept && !beyond)
        begin
            position_step_reg[idx] <= ps_next;
            velocity_step_reg[idx] <= vs_next;
            active_mode_reg[idx]   <= am_next;
            saved_node_reg[idx]    <= sn_next;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_node_reg <= node_next;
            out_cmd_reg  <= cmd_next;
            out_val_reg  <= val_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_node_id = out_node_reg;
    assign rsp.out_command = out_cmd_reg;
    assign rsp.out_value   = out_val_reg;

endmodule

### sv/pmcs_checker.sv
// pmcs_checker: port-level assertions on the sequencer's request and command channels
// depends on pmcs_pkg; bound to profile_mode_command_sequencer_core below

module pmcs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pmcs_pkg::NODE_W-1:0]  out_node_id,
    input logic [pmcs_pkg::CODE_W-1:0]  out_command,
    input logic [pmcs_pkg::VALUE_W-1:0] out_value
);

    // stalled command beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_node_id)
            && $stable(out_command) && $stable(out_value))
        else $error("stalled command beat changed");

    // empty output register never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request blocked with empty output");

    // every request beat gives a command beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("request beat produced no command");

    // no command beat without a request beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("command beat repeated or invented");

endmodule

bind profile_mode_command_sequencer_core pmcs_checker u_pmcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_node_id (rsp.out_node_id),
    .out_command (rsp.out_command),
    .out_value   (rsp.out_value)
);
